// ===== sv/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// Position PnL table package
// Shared widths, codes, types and states of the position PnL table.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int NUM_USERS_DEF       = 16;
  localparam int NUM_SYMBOLS_DEF     = 16;
  localparam int PRICE_FRAC_BITS_DEF = 16;

  localparam int ID_W    = 4;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 24;
  localparam int NET_W   = 32;
  localparam int AVG_W   = 48;
  localparam int PNL_W   = 64;
  localparam int OPND_W  = 64;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int DIVD_W  = AVG_W + NET_W + 2;
  localparam int DIVS_W  = NET_W + 1;
  localparam int IDX_CMP_W = 9;

  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_MARK = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [NET_W-1:0] qty;
    logic [AVG_W-1:0] avg;
    logic [PNL_W-1:0] booked;
  } ppt_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]         user_id;
    logic signed [NET_W-1:0] net_qty;
    logic [AVG_W-1:0]        avg_price;
    logic signed [PNL_W-1:0] realized_pnl;
    logic signed [PNL_W-1:0] unrealized_pnl;
    logic                    overflow;
  } ppt_result_t;

  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } ppt_mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } ppt_div_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL_NEXT,
    ST_WALK,
    ST_EVAL,
    ST_AVG_M1,
    ST_AVG_M2,
    ST_DIV,
    ST_CLOSE,
    ST_OPEN_GO,
    ST_OPEN,
    ST_EMIT,
    ST_FLUSH
  } ppt_state_e;

endpackage

// ===== sv/ppt_if.sv =====
// ----------------------------------------------------------------------------
// Position PnL table channels
// Valid/ready channels for order events and position results.
// ----------------------------------------------------------------------------
interface ppt_in_if import ppt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [ID_W-1:0]    symbol_id;
  logic [ID_W-1:0]    buyer_id;
  logic [ID_W-1:0]    seller_id;
  logic [PRICE_W-1:0] trade_price;
  logic [QTY_W-1:0]   trade_qty;

  modport source (output valid, opcode, symbol_id, buyer_id, seller_id, trade_price,
                  trade_qty, input ready);
  modport sink (input valid, opcode, symbol_id, buyer_id, seller_id, trade_price,
                trade_qty, output ready);
endinterface

interface ppt_out_if import ppt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         user_id;
  logic signed [NET_W-1:0] net_qty;
  logic [AVG_W-1:0]        avg_price;
  logic signed [PNL_W-1:0] realized_pnl;
  logic signed [PNL_W-1:0] unrealized_pnl;
  logic                    overflow;
  logic                    last_result;

  modport source (output valid, user_id, net_qty, avg_price, realized_pnl, unrealized_pnl,
                  overflow, last_result, input ready);
  modport sink (input valid, user_id, net_qty, avg_price, realized_pnl, unrealized_pnl,
                overflow, last_result, output ready);
endinterface

// ===== sv/ppt_mem.sv =====
// ----------------------------------------------------------------------------
// Position table memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppt_mem import ppt_pkg::*; #(
  parameter int DEPTH  = NUM_USERS_DEF * NUM_SYMBOLS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  ppt_entry_t        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output ppt_entry_t        rdata_o
);

  ppt_entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/ppt_mul.sv =====
// ----------------------------------------------------------------------------
// Sequential multiplier
// 64x64 -> 128 product from four registered 32x32 partial products.
// ----------------------------------------------------------------------------
module ppt_mul import ppt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppt_mul_req_t      req_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  localparam int HALF_W = OPND_W / 2;

  logic                busy_q;
  logic [2:0]          cnt_q;
  logic                pp_vld_q;
  logic [OPND_W-1:0]   a_q, b_q;
  logic [OPND_W-1:0]   pp_q, pp_d;
  logic [1:0]          sh_q, sh_d;
  logic [PROD_W-1:0]   acc_q, pp_sh;
  logic [HALF_W-1:0]   a_sel, b_sel;

  always_comb begin
    a_sel = cnt_q[1] ? a_q[OPND_W-1:HALF_W] : a_q[HALF_W-1:0];
    b_sel = cnt_q[0] ? b_q[OPND_W-1:HALF_W] : b_q[HALF_W-1:0];
    pp_d  = OPND_W'(a_sel) * OPND_W'(b_sel);
    sh_d  = 2'(cnt_q[1]) + 2'(cnt_q[0]);
    case (sh_q)
      2'd0:    pp_sh = {{OPND_W{1'b0}}, pp_q};
      2'd1:    pp_sh = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
      default: pp_sh = {pp_q, {OPND_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      pp_vld_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q   <= 1'b1;
      cnt_q    <= '0;
      pp_vld_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q    <= cnt_q + 3'd1;
      pp_vld_q <= (cnt_q < 3'd4);
      if (cnt_q == 3'd5) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        pp_q <= pp_d;
        sh_q <= sh_d;
      end
      if (pp_vld_q) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = busy_q && (cnt_q == 3'd5);
  assign prod_o = acc_q;

endmodule

// ===== sv/ppt_div.sv =====
// ----------------------------------------------------------------------------
// Sequential divider
// Restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppt_div import ppt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppt_div_req_t      req_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] rem_q, dvs_q;
  logic [DIVS_W:0]   rem_sh, rem_n;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_n  = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], ge};
      rem_q <= rem_n[DIVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/position_pnl_table_unit.sv =====
// ----------------------------------------------------------------------------
// Position PnL table unit
// Average-cost position table per user and symbol with realized and
// mark-to-market PnL, held in one synchronous memory.
//
//   channel | dir | payload
//   in_i    | in  | opcode, symbol_id, buyer_id, seller_id, trade_price, trade_qty
//   out_o   | out | user_id, net_qty, avg_price, realized/unrealized_pnl, overflow, last
//
// One transaction at a time. A fill side takes longest when the average is
// re-weighted, where the restoring divider, one bit per cycle, dominates.
// A mark walks all users of the symbol and emits a result for each held entry.
// After reset a clearing pass writes all NUM_USERS * NUM_SYMBOLS entries, ready low.
// Behind a stalled result one more waits; work continues until a third is due.
// ----------------------------------------------------------------------------
module position_pnl_table_unit import ppt_pkg::*; #(
  parameter int NUM_USERS       = NUM_USERS_DEF,
  parameter int NUM_SYMBOLS     = NUM_SYMBOLS_DEF,
  parameter int PRICE_FRAC_BITS = PRICE_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppt_in_if.sink    in_i,
  ppt_out_if.source out_o
);

  localparam int DEPTH   = NUM_USERS * NUM_SYMBOLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int WALK_W  = $clog2(NUM_USERS + 1);
  localparam int ACALC_W = 17;
  localparam int S_W     = NET_W + 2;

  ppt_state_e state_q, state_d;

  logic [ADDR_W-1:0]  clr_q, addr_q, raddr;
  logic               op_q, side_q;
  logic [ID_W-1:0]    sym_q, buyer_q, seller_q, user_q, fill_user;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;
  logic [WALK_W-1:0]  walk_q;
  logic [ACALC_W-1:0] addr_calc;

  logic signed [S_W-1:0] s_q, s_d, q34, qty34;
  logic                  ovf_q, ovf_d;
  logic [NET_W-1:0]      mag_q, mag_d, closing;
  logic [AVG_W-1:0]      avg_n_q, pfx_sat;
  logic [PNL_W-1:0]      booked_n_q, diff;
  logic [OPND_W-1:0]     pfx, avg64;
  logic [DIVD_W-1:0]     p1_q, quo;
  logic                  buy, q_zero, same, flip;

  ppt_result_t new_q, pend_q, out_q;
  logic        pend_vld_q, out_vld_q, out_last_q;
  logic        out_free, accept, user_ok, sym_ok;

  ppt_entry_t   rd, wdata;
  logic         we;
  logic [ADDR_W-1:0] waddr;
  ppt_mul_req_t mul_req;
  ppt_div_req_t div_req;
  logic         mul_done, div_done;
  logic [PROD_W-1:0] prod;

  ppt_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rd)
  );

  ppt_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .done_o(mul_done), .prod_o(prod));

  ppt_div u_div (.clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quo_o(quo));

  // datapath
  always_comb begin
    fill_user = side_q ? seller_q : buyer_q;
    addr_calc = (op_q == OP_MARK) ? ACALC_W'(walk_q) : ACALC_W'(fill_user);
    addr_calc = addr_calc * ACALC_W'(NUM_SYMBOLS) + ACALC_W'(sym_q);
    raddr     = addr_calc[ADDR_W-1:0];
    user_ok   = IDX_CMP_W'(fill_user) < IDX_CMP_W'(NUM_USERS);
    sym_ok    = IDX_CMP_W'(in_i.symbol_id) < IDX_CMP_W'(NUM_SYMBOLS);

    pfx     = OPND_W'(price_q) << PRICE_FRAC_BITS;
    pfx_sat = (|pfx[OPND_W-1:AVG_W]) ? AVG_MAX : pfx[AVG_W-1:0];
    avg64   = OPND_W'(rd.avg);
    buy     = !side_q;
    q34     = {{2{rd.qty[NET_W-1]}}, rd.qty};
    qty34   = S_W'(qty_q);
    s_d     = buy ? q34 + qty34 : q34 - qty34;
    ovf_d   = !((s_d[S_W-1:NET_W-1] == 3'b000) || (s_d[S_W-1:NET_W-1] == 3'b111));
    mag_d   = rd.qty[NET_W-1] ? (~rd.qty + NET_W'(1)) : rd.qty;
    q_zero  = (rd.qty == '0);
    same    = buy ? !rd.qty[NET_W-1] : rd.qty[NET_W-1];
    flip    = buy ? (!s_d[S_W-1] && (s_d != '0)) : s_d[S_W-1];
    closing = (NET_W'(qty_q) < mag_d) ? NET_W'(qty_q) : mag_d;
    diff    = buy ? avg64 - pfx : pfx - avg64;
  end

  assign out_free = !out_vld_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  // control
  always_comb begin
    state_d = state_q;
    mul_req = '0;
    div_req = '0;
    we      = 1'b0;
    waddr   = addr_q;
    wdata   = {1'b1, s_q[NET_W-1:0], avg_n_q, booked_n_q};
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!sym_ok) state_d = ST_FLUSH;
          else if (in_i.opcode == OP_MARK) state_d = ST_WALK;
          else state_d = ST_FILL_NEXT;
        end
      end
      ST_FILL_NEXT: begin
        if (user_ok) state_d = ST_EVAL;
        else if (side_q) state_d = ST_FLUSH;
      end
      ST_WALK: begin
        if (walk_q == WALK_W'(NUM_USERS)) state_d = ST_FLUSH;
        else state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (op_q == OP_MARK) begin
          state_d = rd.valid ? ST_OPEN_GO : ST_WALK;
        end else if (q_zero) begin
          state_d = ST_OPEN_GO;
        end else if (same) begin
          mul_req = '{start: 1'b1, a: avg64, b: OPND_W'(mag_d)};
          state_d = ST_AVG_M1;
        end else begin
          mul_req = '{start: 1'b1, a: diff, b: OPND_W'(closing)};
          state_d = ST_CLOSE;
        end
      end
      ST_AVG_M1: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, a: pfx, b: OPND_W'(qty_q)};
          state_d = ST_AVG_M2;
        end
      end
      ST_AVG_M2: begin
        if (mul_done) begin
          div_req = '{start: 1'b1, dividend: p1_q + prod[DIVD_W-1:0],
                      divisor: DIVS_W'(mag_q) + DIVS_W'(qty_q)};
          state_d = ST_DIV;
        end
      end
      ST_DIV:   if (div_done) state_d = ST_OPEN_GO;
      ST_CLOSE: if (mul_done) state_d = ST_OPEN_GO;
      ST_OPEN_GO: begin
        mul_req = '{start: 1'b1, a: pfx - OPND_W'(avg_n_q),
                    b: {{(OPND_W-NET_W){s_q[NET_W-1]}}, s_q[NET_W-1:0]}};
        state_d = ST_OPEN;
      end
      ST_OPEN: begin
        if (mul_done) begin
          we      = (op_q == OP_FILL);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!pend_vld_q || out_free) begin
          if (op_q == OP_MARK) state_d = ST_WALK;
          else state_d = side_q ? ST_FLUSH : ST_FILL_NEXT;
        end
      end
      ST_FLUSH: if (!pend_vld_q || out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      side_q     <= 1'b0;
      walk_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (accept) begin
        side_q <= 1'b0;
        walk_q <= '0;
      end
      if (state_q == ST_FILL_NEXT && !user_ok) side_q <= 1'b1;
      if (state_q == ST_WALK && state_d == ST_EVAL) walk_q <= walk_q + WALK_W'(1);
      if (state_q == ST_EMIT && state_d != ST_EMIT) begin
        pend_vld_q <= 1'b1;
        if (op_q == OP_FILL) side_q <= 1'b1;
      end
      if (state_q == ST_FLUSH && out_free) pend_vld_q <= 1'b0;
      if (((state_q == ST_EMIT) || (state_q == ST_FLUSH)) && pend_vld_q && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_i.opcode;
      sym_q    <= in_i.symbol_id;
      buyer_q  <= in_i.buyer_id;
      seller_q <= in_i.seller_id;
      price_q  <= in_i.trade_price;
      qty_q    <= in_i.trade_qty;
    end
    if (state_q == ST_FILL_NEXT) begin
      addr_q <= raddr;
      user_q <= fill_user;
    end
    if (state_q == ST_WALK) begin
      addr_q <= raddr;
      user_q <= ID_W'(walk_q);
    end
    if (state_q == ST_EVAL) begin
      booked_n_q <= rd.booked;
      mag_q      <= mag_d;
      if (op_q == OP_MARK) begin
        s_q     <= q34;
        ovf_q   <= 1'b0;
        avg_n_q <= rd.avg;
      end else begin
        s_q     <= s_d;
        ovf_q   <= ovf_d;
        avg_n_q <= (q_zero || flip) ? pfx_sat : rd.avg;
      end
    end
    if (state_q == ST_AVG_M1 && mul_done) p1_q <= prod[DIVD_W-1:0];
    if (state_q == ST_DIV && div_done) begin
      avg_n_q <= (|quo[DIVD_W-1:AVG_W]) ? AVG_MAX : quo[AVG_W-1:0];
    end
    if (state_q == ST_CLOSE && mul_done) booked_n_q <= booked_n_q + prod[PNL_W-1:0];
    if (state_q == ST_OPEN && mul_done) begin
      new_q <= '{user_id: user_q, net_qty: s_q[NET_W-1:0], avg_price: avg_n_q,
                 realized_pnl: booked_n_q, unrealized_pnl: prod[PNL_W-1:0],
                 overflow: ovf_q};
    end
    if (state_q == ST_EMIT && state_d != ST_EMIT) pend_q <= new_q;
    if (((state_q == ST_EMIT) || (state_q == ST_FLUSH)) && pend_vld_q && out_free) begin
      out_q      <= pend_q;
      out_last_q <= (state_q == ST_FLUSH);
    end
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_vld_q;
  assign out_o.user_id        = out_q.user_id;
  assign out_o.net_qty        = out_q.net_qty;
  assign out_o.avg_price      = out_q.avg_price;
  assign out_o.realized_pnl   = out_q.realized_pnl;
  assign out_o.unrealized_pnl = out_q.unrealized_pnl;
  assign out_o.overflow       = out_q.overflow;
  assign out_o.last_result    = out_last_q;

endmodule

// ===== sv/ppt_checker.sv =====
// ----------------------------------------------------------------------------
// Position PnL table checker
// Port-level checks of the position PnL table unit.
// ----------------------------------------------------------------------------
module ppt_checker import ppt_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [ID_W-1:0]         out_user_id_i,
  input logic signed [NET_W-1:0] out_net_qty_i,
  input logic                    out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_user_id_i) &&
    $stable(out_net_qty_i) && $stable(out_last_i))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("ready during clearing pass");

  a_open_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("ready before final result");

endmodule

bind position_pnl_table_unit ppt_checker u_ppt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_user_id_i(out_o.user_id),
  .out_net_qty_i(out_o.net_qty),
  .out_last_i   (out_o.last_result)
);
